### hdl/mbq_pkg.sv
// Shared types, constants and helpers for the mouse button event queue.
// No dependencies; used by every other file of the block except mbq_ram.
`timescale 1ns / 1ps

package mbq_pkg;

  localparam int QUEUE_SLOTS = 32;
  localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
  localparam int CODE_W      = 3;
  localparam int BTN_W       = 8;
  localparam int DELAY_W     = 8;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd10;

  localparam logic [BTN_W-1:0] BTN_LEFT   = 8'h01;
  localparam logic [BTN_W-1:0] BTN_RIGHT  = 8'h02;
  localparam logic [BTN_W-1:0] BTN_MIDDLE = 8'h04;

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  // request passed from front to back
  typedef struct packed {
    logic              pop;
    logic              push;
    logic [CODE_W-1:0] code;
  } op_t;

  // status of an issued request, waiting on the read data
  typedef struct packed {
    logic code_valid;
    logic queue_not_empty;
    logic code_dropped;
  } res_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] n;
    if (s == SLOT_W'(QUEUE_SLOTS - 1)) begin
      n = '0;
    end else begin
      n = s + SLOT_W'(1);
    end
    return n;
  endfunction

endpackage

### hdl/mouse_button_event_queue.sv
// Mouse button event queue: top level joining front end, request queue and back end.
// Depends on mbq_pkg, mbq_front, mbq_opq, mbq_back (and mbq_ram through mbq_back).
`timescale 1ns / 1ps

// Takes one request per clock while the request queue is not full: a button report
// (command 0) or a pop (command 1). Every request gives exactly one result, through
// the request queue, the issue stage and the output register; the rate is set by
// the registered update of the FIFO pointers and the code store's one write and
// one registered read port. Reset leaves the queue empty and the repeat delay at
// 10; the code store needs no clearing. Write the delay only while idle.

module mouse_button_event_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbq_pkg::DELAY_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [mbq_pkg::BTN_W-1:0]     in_buttons,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mbq_pkg::CODE_W-1:0]    out_code,
  output logic                          out_code_valid,
  output logic                          out_queue_not_empty,
  output logic                          out_code_dropped
);

  logic         accept;
  logic         q_full;
  logic         q_valid;
  logic         q_take;
  mbq_pkg::op_t front_op;
  mbq_pkg::op_t head_op;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  mbq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .accept   (accept),
    .command  (in_command),
    .buttons  (in_buttons),
    .op       (front_op)
  );

  mbq_opq u_opq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_op    (front_op),
    .full       (q_full),
    .pop        (q_take),
    .head_valid (q_valid),
    .head_op    (head_op)
  );

  mbq_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (q_valid),
    .req_op              (head_op),
    .req_take            (q_take),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_code            (out_code),
    .out_code_valid      (out_code_valid),
    .out_queue_not_empty (out_queue_not_empty),
    .out_code_dropped    (out_code_dropped)
  );

  // a popped code is one of left, right or middle
  a_code_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_code_valid |-> $onehot(out_code))
    else $error("popped code not one-hot");

  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_code_valid |-> out_code == '0)
    else $error("code present without a popped entry");

  // a drop only happens on a full queue, never on a pop
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_code_dropped |-> out_queue_not_empty && !out_code_valid)
    else $error("drop reported with empty queue or on a pop");

endmodule

### hdl/mbq_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module mbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/mbq_front.sv
// Front end: classifies button reports (press, hold, release) and pops into requests.
// Holds the repeat delay register and hold tracking. Depends on mbq_pkg.
`timescale 1ns / 1ps

module mbq_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mbq_pkg::DELAY_W-1:0]   cfg_data,
  input  logic                          accept,
  input  logic                          command,
  input  logic [mbq_pkg::BTN_W-1:0]     buttons,
  output mbq_pkg::op_t                  op
);

  logic [mbq_pkg::DELAY_W-1:0] delay_r;
  logic [mbq_pkg::BTN_W-1:0]   prev_r, prev_nxt;
  logic [mbq_pkg::DELAY_W-1:0] hold_r, hold_nxt;

  logic                        is_report;
  logic                        has_code;
  logic                        press;
  logic                        held;
  logic [mbq_pkg::DELAY_W-1:0] hold_base;
  logic [mbq_pkg::DELAY_W:0]   cnt;

  always_comb begin
    is_report = (command == mbq_pkg::CMD_REPORT);
    has_code  = (buttons == mbq_pkg::BTN_LEFT) || (buttons == mbq_pkg::BTN_RIGHT) ||
                (buttons == mbq_pkg::BTN_MIDDLE);
    press     = (buttons != '0) && (buttons != prev_r);
    held      = (buttons != '0) && (buttons == prev_r);
    // change away from a nonzero value clears the counter
    hold_base = ((prev_r != '0) && (buttons != prev_r)) ? '0 : hold_r;
    cnt       = {1'b0, hold_base} + 9'd1;

    hold_nxt = hold_base;
    op.pop   = !is_report;
    op.push  = 1'b0;
    op.code  = buttons[mbq_pkg::CODE_W-1:0];
    if (is_report) begin
      if (press) begin
        op.push = has_code;
      end
      if (held) begin
        if (cnt < {1'b0, delay_r}) begin
          hold_nxt = cnt[mbq_pkg::DELAY_W-1:0];
        end else begin
          hold_nxt = delay_r;
          op.push  = has_code;
        end
      end
    end
    prev_nxt = is_report ? buttons : prev_r;
    if (!is_report) begin
      hold_nxt = hold_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= mbq_pkg::DELAY_RESET;
      prev_r  <= '0;
      hold_r  <= '0;
    end else begin
      if (cfg_we) begin
        delay_r <= cfg_data;
      end
      if (accept) begin
        prev_r <= prev_nxt;
        hold_r <= hold_nxt;
      end
    end
  end

endmodule

### hdl/mbq_opq.sv
// Two-entry request queue between front and back ends.
// Depends on mbq_pkg.
`timescale 1ns / 1ps

module mbq_opq (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  mbq_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output mbq_pkg::op_t head_op
);

  mbq_pkg::op_t slot_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_op;
    end
  end

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_op    = slot_r[rp_r];

endmodule

### hdl/mbq_back.sv
// Back end: ring FIFO pointers, code store and output register with its handshake.
// Depends on mbq_pkg and mbq_ram.
`timescale 1ns / 1ps

module mbq_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req_valid,
  input  mbq_pkg::op_t                req_op,
  output logic                        req_take,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mbq_pkg::CODE_W-1:0]  out_code,
  output logic                        out_code_valid,
  output logic                        out_queue_not_empty,
  output logic                        out_code_dropped
);

  logic [mbq_pkg::SLOT_W-1:0] wr_r, wr_nxt;
  logic [mbq_pkg::SLOT_W-1:0] rd_r, rd_nxt;
  logic [mbq_pkg::SLOT_W-1:0] wr_inc, rd_inc;
  logic                       s1_valid_r;
  mbq_pkg::res_t              s1_r, s1_nxt;
  logic                       s1_go;
  logic                       issue;
  logic                       do_write, do_read;
  logic [mbq_pkg::CODE_W-1:0] rdata;

  logic                       out_valid_r;
  logic [mbq_pkg::CODE_W-1:0] out_code_r;
  mbq_pkg::res_t              out_res_r;

  always_comb begin
    s1_go  = s1_valid_r && (!out_valid_r || out_ready);
    issue  = req_valid && (!s1_valid_r || s1_go);
    wr_inc = mbq_pkg::next_slot(wr_r);
    rd_inc = mbq_pkg::next_slot(rd_r);

    do_read  = issue && req_op.pop && (wr_r != rd_r);
    do_write = issue && req_op.push && (wr_inc != rd_r);
    wr_nxt   = do_write ? wr_inc : wr_r;
    rd_nxt   = do_read ? rd_inc : rd_r;

    s1_nxt.code_valid      = do_read;
    s1_nxt.queue_not_empty = (wr_nxt != rd_nxt);
    s1_nxt.code_dropped    = req_op.push && (wr_inc == rd_r);
  end

  mbq_ram #(
    .WIDTH (mbq_pkg::CODE_W),
    .DEPTH (mbq_pkg::QUEUE_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (do_write),
    .waddr (wr_inc),
    .wdata (req_op.code),
    .re    (do_read),
    .raddr (rd_inc),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r        <= '0;
      rd_r        <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      if (issue) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_r <= s1_nxt;
    end
    if (s1_go) begin
      out_res_r  <= s1_r;
      out_code_r <= s1_r.code_valid ? rdata : '0;
    end
  end

  assign req_take            = issue;
  assign out_valid           = out_valid_r;
  assign out_code            = out_code_r;
  assign out_code_valid      = out_res_r.code_valid;
  assign out_queue_not_empty = out_res_r.queue_not_empty;
  assign out_code_dropped    = out_res_r.code_dropped;

endmodule
